// File: rtl/asv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asv_pkg
// Types, codes and character rules shared by the ASN.1 string validator.
// ----------------------------------------------------------------------------
package asv_pkg;

   // Universal tag numbers of the string types that are checked.
   localparam logic [4:0] TAG_UTF8      = 5'd12;
   localparam logic [4:0] TAG_PRINTABLE = 5'd19;
   localparam logic [4:0] TAG_T61       = 5'd20;
   localparam logic [4:0] TAG_IA5       = 5'd22;
   localparam logic [4:0] TAG_VISIBLE   = 5'd26;

   localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;

   // Character bounds.
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7a;
   localparam logic [7:0] CHAR_ASTERISK   = 8'h2a;
   localparam logic [7:0] CHAR_SEMICOLON  = 8'h3b;
   localparam logic [7:0] CHAR_LESS       = 8'h3c;
   localparam logic [7:0] CHAR_GREATER    = 8'h3e;
   localparam logic [7:0] CHAR_AT         = 8'h40;
   localparam logic [7:0] CHAR_ASCII_MAX  = 8'h7f;
   localparam logic [7:0] UTF8_LEAD2_MIN  = 8'hC2;
   localparam logic [7:0] UTF8_LEAD_WIDE  = 8'hD0;
   localparam logic [7:0] UTF8_LEAD_LIMIT = 8'hF5;

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_PRINTABLE = 2'd1,
      KIND_ASCII     = 2'd2,
      KIND_UTF8      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE          = 3'd0,
      ERR_NOT_UNIVERSAL = 3'd1,
      ERR_BAD_CHAR      = 3'd2,
      ERR_BAD_LEAD      = 3'd3,
      ERR_BAD_CONT      = 3'd4,
      ERR_TRUNCATED     = 3'd5,
      ERR_UNKNOWN_TAG   = 3'd6
   } error_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   // One input item as held in the input register.
   typedef struct packed {
      logic [1:0] string_class;
      logic [4:0] string_tag;
      logic [7:0] content_byte;
      logic       byte_present;
      logic       first_item;
      logic       last_item;
   } req_item_type;

   function automatic kind_type kind_of_tag(input logic [4:0] tag);
      kind_type kind;
      unique case (tag) inside
         TAG_PRINTABLE:                   kind = KIND_PRINTABLE;
         TAG_T61, TAG_IA5, TAG_VISIBLE:   kind = KIND_ASCII;
         TAG_UTF8:                        kind = KIND_UTF8;
         default:                         kind = KIND_NONE;
      endcase
      return kind;
   endfunction

   // PrintableString: space, or 0x27..0x7A less a handful of punctuation marks.
   function automatic logic printable_ok(input logic [7:0] b);
      logic ok;
      if (b == CHAR_SPACE) begin
         ok = 1'b1;
      end else if (b < CHAR_APOSTROPHE || b > CHAR_LOWER_Z) begin
         ok = 1'b0;
      end else begin
         ok = !(b == CHAR_ASTERISK || b == CHAR_SEMICOLON || b == CHAR_LESS ||
                b == CHAR_GREATER || b == CHAR_AT);
      end
      return ok;
   endfunction

   function automatic status_type status_of(input error_type err);
      status_type st;
      unique case (err)
         ERR_NONE:        st = STATUS_OK;
         ERR_UNKNOWN_TAG: st = STATUS_INVALID;
         default:         st = STATUS_MALFORMED;
      endcase
      return st;
   endfunction

endpackage

// File: rtl/asv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asv_req_if / asv_rsp_if
// Valid/ready channels for string bytes in and the status out.
// ----------------------------------------------------------------------------
interface asv_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] string_class;
   logic [4:0] string_tag;
   logic [7:0] content_byte;
   logic       byte_present;
   logic       first_item;
   logic       last_item;

   modport source (output valid, string_class, string_tag, content_byte,
                   byte_present, first_item, last_item, input ready);
   modport sink   (input valid, string_class, string_tag, content_byte,
                   byte_present, first_item, last_item, output ready);
endinterface

interface asv_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [2:0] error_detail;

   modport source (output valid, status, error_detail, input ready);
   modport sink   (input valid, status, error_detail, output ready);
endinterface

// File: rtl/asn1_string_charset_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asn1_string_charset_validator
// Checks the content bytes of an ASN.1 string and reports one status per string.
// ----------------------------------------------------------------------------
// The block takes one content byte of an ASN.1 string per item, with class and
// tag read from the item marked first, and gives one result item for each item
// marked last: status 0 ok, 1 malformed, 2 invalid, plus the detail code of the
// first error seen in the string. An item enters an input register, is checked
// against the string state by short compare logic, and its result lands in an
// output register. One item is accepted every clock cycle while the input is
// not held back; the only loop is the per-byte update of the UTF-8 and error
// state. A last item passes from the input register into the output register,
// where its result waits until it is taken.
// The output register parts the two sides, so the next item is taken
// while a finished result waits, and only a result that cannot be handed on
// holds the input back.
// ----------------------------------------------------------------------------
module asn1_string_charset_validator
   import asv_pkg::*;
(
   input logic          clock,
   input logic          reset,
   asv_req_if.sink      req_chan,
   asv_rsp_if.source    rsp_chan
);

   // Input register.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;

   // String state.
   kind_type   kind_ff, kind_in;
   error_type  err_ff, err_in;
   logic       cont_ff, cont_in;
   logic [1:0] pend_ff, pend_in;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   error_type  out_detail_ff, out_detail_in;

   logic out_free;
   logic in_advance;
   logic req_take;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   // An item that is not last leaves no result, so it never waits on the output.
   assign in_advance = in_valid_ff && (!in_item_ff.last_item || out_free);
   assign req_chan.ready = !in_valid_ff || in_advance;
   assign req_take   = req_chan.valid && req_chan.ready;
   assign in_valid_in = req_take || (in_valid_ff && !in_advance);

   // Check of the held item against the string state.
   always_comb begin
      kind_type   kind_w;
      error_type  err_w;
      logic       cont_w;
      logic [1:0] pend_w;
      logic [7:0] b;

      b = in_item_ff.content_byte;

      if (in_item_ff.first_item) begin
         kind_w = kind_of_tag(in_item_ff.string_tag);
         cont_w = 1'b0;
         pend_w = 2'd0;
         if (in_item_ff.string_class != CLASS_UNIVERSAL) begin
            err_w = ERR_NOT_UNIVERSAL;
         end else if (kind_w == KIND_NONE) begin
            err_w = ERR_UNKNOWN_TAG;
         end else begin
            err_w = ERR_NONE;
         end
      end else begin
         kind_w = kind_ff;
         err_w  = err_ff;
         cont_w = cont_ff;
         pend_w = pend_ff;
      end

      // Once an error is latched, the rest of the string is ignored.
      if (in_item_ff.byte_present && err_w == ERR_NONE) begin
         unique case (kind_w)
            KIND_PRINTABLE: begin
               if (!printable_ok(b)) err_w = ERR_BAD_CHAR;
            end
            KIND_ASCII: begin
               if (b < CHAR_SPACE || b > CHAR_ASCII_MAX) err_w = ERR_BAD_CHAR;
            end
            KIND_UTF8: begin
               if (!cont_w) begin
                  if (b[7] == 1'b0) begin
                     // Plain ASCII stands alone.
                  end else if (b >= UTF8_LEAD2_MIN && b < UTF8_LEAD_WIDE) begin
                     pend_w = 2'd1;
                     cont_w = 1'b1;
                  end else if (b >= UTF8_LEAD_WIDE && b < UTF8_LEAD_LIMIT) begin
                     // Leads 0xDx, 0xEx and 0xFx expect one, two or three more bytes.
                     pend_w = b[5:4];
                     cont_w = 1'b1;
                  end else begin
                     err_w = ERR_BAD_LEAD;
                  end
               end else if (b[7:6] != 2'b10) begin
                  err_w = ERR_BAD_CONT;
               end else begin
                  pend_w = pend_w - 2'd1;
                  if (pend_w == 2'd0) cont_w = 1'b0;
               end
            end
            default: begin
               // Bytes with no string opened since reset.
               err_w = ERR_UNKNOWN_TAG;
            end
         endcase
      end

      // A UTF-8 sequence still open at the end of the string is cut off.
      if (in_item_ff.last_item && err_w == ERR_NONE && kind_w == KIND_UTF8 && cont_w) begin
         err_w = ERR_TRUNCATED;
      end

      kind_in       = kind_w;
      err_in        = err_w;
      cont_in       = cont_w;
      pend_in       = pend_w;
      out_status_in = status_of(err_w);
      out_detail_in = err_w;
   end

   assign out_valid_in = (in_advance && in_item_ff.last_item) ||
                         (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         kind_ff      <= KIND_NONE;
         err_ff       <= ERR_NONE;
         cont_ff      <= 1'b0;
         pend_ff      <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_advance) begin
            kind_ff <= kind_in;
            err_ff  <= err_in;
            cont_ff <= cont_in;
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.string_class <= req_chan.string_class;
         in_item_ff.string_tag   <= req_chan.string_tag;
         in_item_ff.content_byte <= req_chan.content_byte;
         in_item_ff.byte_present <= req_chan.byte_present;
         in_item_ff.first_item   <= req_chan.first_item;
         in_item_ff.last_item    <= req_chan.last_item;
      end
      if (in_advance && in_item_ff.last_item) begin
         out_status_ff <= out_status_in;
         out_detail_ff <= out_detail_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.error_detail = out_detail_ff;

   // Continuation bytes are expected exactly when the count is nonzero.
   a_cont_matches_count: assert property (@(posedge clock) disable iff (reset)
      cont_ff == (pend_ff != 2'd0))
      else $error("continuation flag and pending count disagree");

   // The status always follows from the detail code.
   a_status_mapping: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_status_ff == STATUS_OK) == (out_detail_ff == ERR_NONE)) &&
                       ((out_status_ff == STATUS_INVALID) == (out_detail_ff == ERR_UNKNOWN_TAG)))
      else $error("status does not match error detail");

   // A held item that cannot advance stays put in the input register.
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("stalled item lost from input register");

   // A last item only leaves the input register into a free result register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_advance && in_item_ff.last_item) |-> out_free)
      else $error("result register overwritten");

endmodule
